// File: hdl/dfs_pkg.sv
// Shared types, constants and helpers of the decimal fixed-point square root.
`timescale 1ns / 1ps

package dfs_pkg;

    localparam int VALUE_W         = 32;
    localparam int ROOT_W          = 33;
    localparam int NUM_W           = 2 * ROOT_W;
    localparam int REM_W           = ROOT_W + 2;
    localparam int DIGIT_W         = 3;
    localparam int MAX_FRAC_DIGITS = 5;
    localparam int SCALE_CELLS     = MAX_FRAC_DIGITS;
    localparam int ROOT_CELLS      = ROOT_W;
    localparam int TDATA_W         = ((ROOT_W + 7) / 8) * 8;

    localparam logic [DIGIT_W-1:0] FRAC_DIGITS_RESET = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] FRAC_DIGITS_LIMIT = DIGIT_W'(MAX_FRAC_DIGITS);

    // Word moving through the decimal scaling cells.
    typedef struct packed {
        logic               valid;
        logic               neg;
        logic [DIGIT_W-1:0] count;
        logic [NUM_W-1:0]   num;
    } scale_word_t;

    // Word moving through the root cells.
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [NUM_W-1:0]  num;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_word_t;

    // Multiply by one hundred as 64n + 32n + 4n.
    function automatic logic [NUM_W-1:0] times_hundred(input logic [NUM_W-1:0] n);
        times_hundred = (n << 6) + (n << 5) + (n << 2);
    endfunction

endpackage

// File: hdl/dfs_scale_cell.sv
// One decimal scaling cell: multiplies by one hundred while digits remain.
`timescale 1ns / 1ps

module dfs_scale_cell
    import dfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  scale_word_t up_word,
    output logic        up_ready,
    output scale_word_t down_word,
    input  logic        down_ready
);

    scale_word_t word_reg;
    scale_word_t word_next;

    assign up_ready = !word_reg.valid || down_ready;

    always_comb begin
        word_next = up_word;
        if (up_word.count != '0) begin
            word_next.num   = times_hundred(up_word.num);
            word_next.count = up_word.count - DIGIT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (up_ready) begin
            word_reg <= word_next;
        end
    end

    assign down_word = word_reg;

`ifndef SYNTH
    // A negative word carries no magnitude and no pending digits.
    a_neg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        word_reg.valid && word_reg.neg |-> word_reg.num == '0 && word_reg.count == '0)
        else $error("negative word carries data");
`endif

endmodule

// File: hdl/dfs_root_cell.sv
// One root cell: takes the next two bits of the number and settles one root bit.
`timescale 1ns / 1ps

module dfs_root_cell
    import dfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  root_word_t up_word,
    output logic       up_ready,
    output root_word_t down_word,
    input  logic       down_ready
);

    root_word_t           word_reg;
    root_word_t           word_next;
    logic [REM_W+1:0]     rem_shift;
    logic [REM_W+1:0]     trial;
    logic [REM_W+1:0]     diff;
    logic                 fits;

    assign up_ready = !word_reg.valid || down_ready;

    always_comb begin
        rem_shift = {up_word.rem, up_word.num[NUM_W-1 -: 2]};
        trial     = {2'b00, up_word.root, 2'b01};
        diff      = rem_shift - trial;
        fits      = rem_shift >= trial;

        word_next       = up_word;
        word_next.num   = {up_word.num[NUM_W-3:0], 2'b00};
        word_next.root  = {up_word.root[ROOT_W-2:0], fits};
        word_next.rem   = fits ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (up_ready) begin
            word_reg <= word_next;
        end
    end

    assign down_word = word_reg;

`ifndef SYNTH
    // The partial remainder never exceeds twice the partial root.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        word_reg.valid |-> {1'b0, word_reg.rem} <= {2'b00, word_reg.root, 1'b0})
        else $error("root remainder out of bound");
`endif

endmodule

// File: hdl/decimal_fixed_point_sqrt.sv
// Top level of the decimal fixed-point square root.
`timescale 1ns / 1ps
//
//  Channel   Direction  Content
//  s_        in         tdata[31:0] = value_in (signed)
//  m_        out        tdata[32:0] = scaled_root, upper bits zero; tuser = negative_input
//  cfg_wr_   in         frac_digits, 3 bits, reset 5, values above 5 act as 5
//
//  Every word passes 38 register stages: five scaling cells, then 33 root
//  cells, one root bit each. A new word can enter every cycle as long as
//  m_ takes each result, that is while m_tready stays high.
//  Each cell moves on when it is empty or its neighbor takes its word, so a
//  stalled m_ side still lets words fill the empty cells behind it.
//  Reset clears the valid bit of every cell and sets frac_digits to 5.
//
//  The input is first scaled by 100 once per fraction digit, exactly, and
//  then the integer square root of that 66-bit value is taken. The floor of
//  that root is floor(sqrt(value_in) * 10^k). A negative input travels with
//  zero magnitude and no scaling, which gives a zero root and the flag.

module decimal_fixed_point_sqrt
    import dfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [DIGIT_W-1:0] cfg_wr_data,   // frac_digits

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,       // [31:0] value_in

    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,       // [32:0] scaled_root, rest zero
    output logic               m_tuser        // [0] negative_input
);

    logic [DIGIT_W-1:0] frac_digits_reg;
    logic [DIGIT_W-1:0] digits_used;

    scale_word_t scale_w   [SCALE_CELLS+1];
    logic        scale_rdy [SCALE_CELLS+1];
    root_word_t  root_w    [ROOT_CELLS+1];
    logic        root_rdy  [ROOT_CELLS+1];

    // The register must only be written while the block is idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_digits_reg <= FRAC_DIGITS_RESET;
        end else if (cfg_wr_en) begin
            frac_digits_reg <= cfg_wr_data;
        end
    end

    assign digits_used = (frac_digits_reg > FRAC_DIGITS_LIMIT) ? FRAC_DIGITS_LIMIT
                                                                : frac_digits_reg;

    // Build the entry word. A negative input enters as zero with no digits.
    always_comb begin
        scale_w[0].valid = s_tvalid;
        scale_w[0].neg   = s_tdata[VALUE_W-1];
        if (s_tdata[VALUE_W-1]) begin
            scale_w[0].count = '0;
            scale_w[0].num   = '0;
        end else begin
            scale_w[0].count = digits_used;
            scale_w[0].num   = {{(NUM_W-VALUE_W+1){1'b0}}, s_tdata[VALUE_W-2:0]};
        end
    end

    assign s_tready = scale_rdy[0];

    for (genvar i = 0; i < SCALE_CELLS; i++) begin : g_scale
        dfs_scale_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .up_word    (scale_w[i]),
            .up_ready   (scale_rdy[i]),
            .down_word  (scale_w[i+1]),
            .down_ready (scale_rdy[i+1])
        );
    end

    // Hand over from the scaling row to the root row.
    always_comb begin
        root_w[0].valid = scale_w[SCALE_CELLS].valid;
        root_w[0].neg   = scale_w[SCALE_CELLS].neg;
        root_w[0].num   = scale_w[SCALE_CELLS].num;
        root_w[0].rem   = '0;
        root_w[0].root  = '0;
    end

    assign scale_rdy[SCALE_CELLS] = root_rdy[0];

    for (genvar j = 0; j < ROOT_CELLS; j++) begin : g_root
        dfs_root_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .up_word    (root_w[j]),
            .up_ready   (root_rdy[j]),
            .down_word  (root_w[j+1]),
            .down_ready (root_rdy[j+1])
        );
    end

    // The last root cell is the output register.
    assign root_rdy[ROOT_CELLS] = m_tready;
    assign m_tvalid = root_w[ROOT_CELLS].valid;
    assign m_tdata  = {{(TDATA_W-ROOT_W){1'b0}}, root_w[ROOT_CELLS].root};
    assign m_tuser  = root_w[ROOT_CELLS].neg;

`ifndef SYNTH
    // A flagged result always carries a zero root.
    a_neg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("negative input gave a nonzero root");

    // With the output register empty the whole row can move, so input is open.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output is empty");

    // The digit count that enters the row never passes the limit.
    a_digits_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> scale_w[0].count <= FRAC_DIGITS_LIMIT)
        else $error("digit count above limit");
`endif

endmodule
